/* src/hdlc_nrzi_receive_deframer_assert.svh */
// Assertion macros shared by the deframer RTL.
`ifndef HDLC_NRZI_RECEIVE_DEFRAMER_ASSERT_SVH
`define HDLC_NRZI_RECEIVE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HNRD_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hnrd: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HNRD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hnrd: next-cycle check failed");

`endif

/* src/hnrd_pkg.sv */
// Types and constants of the HDLC NRZI receive deframer.
package hnrd_pkg;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BAD_FCS = 3'd2,
        KIND_BAD_LEN = 3'd3,
        KIND_ABORT   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        last;
        logic [11:0] bytes;
    } result_t;

    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
    localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;

    localparam logic [7:0] MIN_FRAME_RESET = 8'd3;

    // Register index, taken from paddr[2].
    localparam logic REG_MIN_FRAME = 1'b0;

endpackage

/* src/hnrd_cfg.sv */
// APB register block holding the minimum frame length.
module hnrd_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  min_frame
);

    logic [7:0] min_frame_reg;
    logic [7:0] min_frame_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == hnrd_pkg::REG_MIN_FRAME);

    always_comb
    begin
        min_frame_next = min_frame_reg;
        if (wr_en)
        begin
            min_frame_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_reg <= hnrd_pkg::MIN_FRAME_RESET;
        end
        else
        begin
            min_frame_reg <= min_frame_next;
        end
    end

    assign prdata    = (paddr[2] == hnrd_pkg::REG_MIN_FRAME) ? {24'd0, min_frame_reg} : 32'd0;
    assign min_frame = min_frame_reg;

endmodule

/* src/hnrd_core.sv */
// Input register and the single-pass NRZI, destuff, flag and CRC logic.
module hnrd_core #(
    parameter int COUNT_MAX = 4095
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_level,
    output logic               in_ready,
    input  logic [7:0]         min_frame,
    input  logic               out_free,
    output logic               res_load,
    output hnrd_pkg::result_t  res
);

    localparam int CNT_W = $clog2(COUNT_MAX + 1);

    logic             in_valid_reg, in_valid_next;
    logic             level_reg;
    logic             consume;

    logic             ref_reg, ref_next;
    logic             primed_reg, primed_next;
    logic [2:0]       ones_reg, ones_next;
    logic             in_frame_reg, in_frame_next;
    logic [6:0]       dly_reg, dly_next;
    logic [2:0]       fill_reg, fill_next;
    logic [7:0]       shift_reg, shift_next;
    logic [2:0]       pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_valid;

    assign consume  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || consume;
    assign res_load = consume && res_valid;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        logic       b;
        logic [2:0] ones_up;
        logic       push_en;
        logic       push_bit;
        logic       restart;
        logic       oldest;
        logic [7:0] shift_byte;

        b          = 1'b0;
        ones_up    = ones_reg;
        push_en    = 1'b0;
        push_bit   = 1'b0;
        restart    = 1'b0;
        oldest     = 1'b0;
        shift_byte = shift_reg;

        ref_next      = ref_reg;
        primed_next   = primed_reg;
        ones_next     = ones_reg;
        in_frame_next = in_frame_reg;
        dly_next      = dly_reg;
        fill_next     = fill_reg;
        shift_next    = shift_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        cnt_next      = cnt_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (!primed_reg)
        begin
            // The first symbol only sets the NRZI reference.
            ref_next    = level_reg;
            primed_next = 1'b1;
        end
        else
        begin
            b        = (level_reg == ref_reg);
            ref_next = level_reg;
            if (b)
            begin
                ones_up   = (ones_reg != 3'd7) ? ones_reg + 3'd1 : ones_reg;
                ones_next = ones_up;
                if (ones_up == 3'd7 && ones_reg == 3'd6)
                begin
                    if (in_frame_reg)
                    begin
                        res_valid     = 1'b1;
                        res.kind      = hnrd_pkg::KIND_ABORT;
                        res.last      = 1'b1;
                        res.bytes     = 12'(cnt_reg);
                        in_frame_next = 1'b0;
                        restart       = 1'b1;
                    end
                end
                else if (in_frame_reg && ones_up != 3'd7)
                begin
                    push_en  = 1'b1;
                    push_bit = 1'b1;
                end
            end
            else
            begin
                ones_next = 3'd0;
                if (ones_reg == 3'd5)
                begin
                    // Stuffed zero is dropped.
                end
                else if (ones_reg == 3'd6)
                begin
                    // A flag closes any frame with content and opens the next.
                    if (in_frame_reg && (cnt_reg != '0 || pos_reg != 3'd0))
                    begin
                        res_valid = 1'b1;
                        res.last  = 1'b1;
                        res.bytes = 12'(cnt_reg);
                        if (pos_reg != 3'd0 || cnt_reg < CNT_W'(min_frame))
                        begin
                            res.kind = hnrd_pkg::KIND_BAD_LEN;
                        end
                        else if (crc_reg == hnrd_pkg::CRC_RESIDUE)
                        begin
                            res.kind = hnrd_pkg::KIND_GOOD;
                        end
                        else
                        begin
                            res.kind = hnrd_pkg::KIND_BAD_FCS;
                        end
                    end
                    in_frame_next = 1'b1;
                    restart       = 1'b1;
                end
                else if (in_frame_reg)
                begin
                    push_en  = 1'b1;
                    push_bit = 1'b0;
                end
            end
        end

        if (push_en)
        begin
            if (fill_reg != 3'd7)
            begin
                dly_next  = dly_reg | (7'(push_bit) << fill_reg);
                fill_next = fill_reg + 3'd1;
            end
            else
            begin
                // The seven-bit delay keeps closing flag bits out of the frame.
                oldest     = dly_reg[0];
                dly_next   = {push_bit, dly_reg[6:1]};
                crc_next   = (crc_reg >> 1) ^ ((crc_reg[0] ^ oldest) ? hnrd_pkg::CRC_POLY : 16'd0);
                shift_byte = shift_reg | (8'(oldest) << pos_reg);
                if (pos_reg == 3'd7)
                begin
                    shift_next = 8'd0;
                    pos_next   = 3'd0;
                    cnt_next   = (cnt_reg < CNT_W'(COUNT_MAX)) ? cnt_reg + CNT_W'(1) : cnt_reg;
                    res_valid  = 1'b1;
                    res.kind   = hnrd_pkg::KIND_DATA;
                    res.data   = shift_byte;
                    res.bytes  = 12'(cnt_next);
                end
                else
                begin
                    shift_next = shift_byte;
                    pos_next   = pos_reg + 3'd1;
                end
            end
        end

        if (restart)
        begin
            dly_next   = 7'd0;
            fill_next  = 3'd0;
            shift_next = 8'd0;
            pos_next   = 3'd0;
            crc_next   = hnrd_pkg::CRC_PRESET;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= in_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ref_reg      <= 1'b0;
            primed_reg   <= 1'b0;
            ones_reg     <= 3'd0;
            in_frame_reg <= 1'b0;
            dly_reg      <= 7'd0;
            fill_reg     <= 3'd0;
            shift_reg    <= 8'd0;
            pos_reg      <= 3'd0;
            crc_reg      <= hnrd_pkg::CRC_PRESET;
            cnt_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                ref_reg      <= ref_next;
                primed_reg   <= primed_next;
                ones_reg     <= ones_next;
                in_frame_reg <= in_frame_next;
                dly_reg      <= dly_next;
                fill_reg     <= fill_next;
                shift_reg    <= shift_next;
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

endmodule

/* src/hnrd_out.sv */
// Result register facing the output stream.
module hnrd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hnrd_pkg::result_t res,
    input  logic              ready,
    output logic              valid,
    output logic              free,
    output hnrd_pkg::result_t held
);

    logic              valid_reg, valid_next;
    hnrd_pkg::result_t held_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign valid = valid_reg;
    assign held  = held_reg;

endmodule

/* src/hdlc_nrzi_receive_deframer.sv */
// Top level of the HDLC receive deframer with NRZI decoding and FCS check.
//
//  Channel  Direction  Signals                             Contents
//  s_*      in         s_tvalid s_tready s_tdata[7:0]      one line symbol per word
//  m_*      out        m_tvalid m_tready m_tdata m_tuser   byte or frame end per word
//                      m_tlast
//  apb      in/out     psel penable pwrite paddr pwdata    min_frame_bytes at 0x0
//                      prdata pready
//
// One symbol is taken per cycle while the result register is free; its whole step
// runs combinationally between the input register and the result register.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled result holds in the output register; the input register still takes
// one more symbol, and further input waits until the result is taken.
`include "hdlc_nrzi_receive_deframer_assert.svh"

module hdlc_nrzi_receive_deframer #(
    parameter int COUNT_MAX = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [19:8] frame_bytes, [23:20] zero
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              out_free;
    logic              res_load;
    logic [7:0]        min_frame;
    hnrd_pkg::result_t res;
    hnrd_pkg::result_t held;

    hnrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .min_frame (min_frame)
    );

    hnrd_core #(
        .COUNT_MAX (COUNT_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_level  (s_tdata[0]),
        .in_ready  (s_tready),
        .min_frame (min_frame),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res)
    );

    hnrd_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .res   (res),
        .ready (m_tready),
        .valid (m_tvalid),
        .free  (out_free),
        .held  (held)
    );

    assign m_tdata = {4'd0, held.bytes, held.data};
    assign m_tuser = held.kind;
    assign m_tlast = held.last;

    `HNRD_ASSERT_IMPLIES(a_last_matches_kind, clk, rst_n, m_tvalid,
        m_tlast == (m_tuser != hnrd_pkg::KIND_DATA))
    `HNRD_ASSERT_IMPLIES(a_end_has_no_byte, clk, rst_n, m_tvalid && m_tlast,
        m_tdata[7:0] == 8'd0)
    `HNRD_ASSERT_NEXT(a_no_load_while_stalled, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

/* sim/hdlc_nrzi_receive_deframer_tb.sv */
// Self-checking testbench for the HDLC NRZI receive deframer: directed frames, then random traffic.
module hdlc_nrzi_receive_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_COUNT_MAX = 4095;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS = 22;

    typedef enum logic [1:0] {
        SEG_RAW,    // line levels sent as they are
        SEG_PLAIN,  // decoded bits, no stuffing (flags, aborts, junk)
        SEG_DATA,   // decoded frame bits, zero stuffed and covered by the FCS
        SEG_FCS     // FCS of the frame so far, XOR a corruption mask
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t       seg;
        logic [5:0]      nbits;
        logic [31:0]     bits;
        logic            check;
        hnrd_pkg::kind_t want_kind;
        logic [11:0]     want_bytes;
    } stim_row_t;

    // Bits go out from bit 0 upward. Rows with check set carry the frame end word
    // that their last symbol must produce.
    stim_row_t stim_rows [NUM_ROWS] = '{
        '{SEG_RAW,   6'd1,  32'h1,      1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7F,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_DATA,  6'd24, 32'h7EFF00, 1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_FCS,   6'd16, 32'h0,      1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b1, hnrd_pkg::KIND_GOOD,    12'd5},
        '{SEG_DATA,  6'd16, 32'h1234,   1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_FCS,   6'd16, 32'h0001,   1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b1, hnrd_pkg::KIND_BAD_FCS, 12'd4},
        '{SEG_DATA,  6'd8,  32'hA5,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b1, hnrd_pkg::KIND_BAD_LEN, 12'd1},
        '{SEG_DATA,  6'd12, 32'h5A5,    1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b1, hnrd_pkg::KIND_BAD_LEN, 12'd1},
        '{SEG_DATA,  6'd16, 32'hFFFF,   1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd7,  32'h7F,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'hFE,     1'b1, hnrd_pkg::KIND_ABORT,   12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_DATA,  6'd8,  32'h01,     1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_FCS,   6'd16, 32'h0,      1'b0, hnrd_pkg::KIND_DATA,    12'd0},
        '{SEG_PLAIN, 6'd8,  32'h7E,     1'b1, hnrd_pkg::KIND_GOOD,    12'd3}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [0] line_level, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;          // [7:0] data_byte, [19:8] frame_bytes, [23:20] zero
    logic [2:0]  m_tuser;          // [2:0] result_kind
    logic        m_tlast;          // frame_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    hdlc_nrzi_receive_deframer #(
        .COUNT_MAX(FRAME_COUNT_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Deframer state as the line should leave it.
    logic        pr_ref = 1'b0;
    logic        pr_primed = 1'b0;
    logic [2:0]  pr_ones = 3'd0;
    logic        pr_in_frame = 1'b0;
    logic [6:0]  pr_dly = 7'd0;
    logic [2:0]  pr_fill = 3'd0;
    logic [7:0]  pr_shift = 8'd0;
    logic [2:0]  pr_pos = 3'd0;
    logic [15:0] pr_crc = hnrd_pkg::CRC_PRESET;
    logic [11:0] pr_count = 12'd0;
    logic [7:0]  pr_min = hnrd_pkg::MIN_FRAME_RESET;

    hnrd_pkg::result_t expected_words [$];

    // Line encoder state on the sending side.
    logic        tx_level = 1'b0;
    int          tx_ones = 0;
    logic [15:0] tx_crc = hnrd_pkg::CRC_PRESET;
    logic        tx_open = 1'b0;

    int burst_left = 0;
    int ready_hold = 0;
    int cycle_count = 0;
    int symbols_sent = 0;
    int words_checked = 0;
    int frame_ends = 0;
    int settings_used = 1;
    int error_count = 0;
    hnrd_pkg::result_t want;

    function void push_word(input hnrd_pkg::kind_t k, input logic [7:0] d, input logic l);
        hnrd_pkg::result_t w;
        w = '{kind: k, data: d, last: l, bytes: pr_count};
        expected_words.insert(expected_words.size(), w);
    endfunction

    function void restart_frame_state();
        pr_dly = 7'd0;
        pr_fill = 3'd0;
        pr_shift = 8'd0;
        pr_pos = 3'd0;
        pr_crc = hnrd_pkg::CRC_PRESET;
        pr_count = 12'd0;
    endfunction

    function void assemble_bit(input logic b);
        logic fb;
        logic [7:0] done_byte;
        fb = pr_crc[0] ^ b;
        pr_crc = (pr_crc >> 1) ^ (fb ? hnrd_pkg::CRC_POLY : 16'h0000);
        pr_shift[pr_pos] = b;
        if (pr_pos == 3'd7)
        begin
            done_byte = pr_shift;
            pr_pos = 3'd0;
            pr_shift = 8'd0;
            if (pr_count < FRAME_COUNT_MAX)
                pr_count = pr_count + 12'd1;
            push_word(hnrd_pkg::KIND_DATA, done_byte, 1'b0);
        end
        else
            pr_pos = pr_pos + 3'd1;
    endfunction

    // The seven newest bits stay in the delay line so a closing flag never lands in a byte.
    function void shift_frame_bit(input logic b);
        logic oldest;
        if (pr_fill < 3'd7)
        begin
            pr_dly[pr_fill] = b;
            pr_fill = pr_fill + 3'd1;
        end
        else
        begin
            oldest = pr_dly[0];
            pr_dly = {b, pr_dly[6:1]};
            assemble_bit(oldest);
        end
    endfunction

    function void close_on_flag();
        hnrd_pkg::kind_t k;
        if (pr_in_frame && (pr_count != 12'd0 || pr_pos != 3'd0))
        begin
            if (pr_pos != 3'd0 || pr_count < {4'd0, pr_min})
                k = hnrd_pkg::KIND_BAD_LEN;
            else if (pr_crc == hnrd_pkg::CRC_RESIDUE)
                k = hnrd_pkg::KIND_GOOD;
            else
                k = hnrd_pkg::KIND_BAD_FCS;
            push_word(k, 8'd0, 1'b1);
        end
        pr_in_frame = 1'b1;
        restart_frame_state();
    endfunction

    function void deframe_symbol(input logic lvl);
        logic b;
        logic [2:0] was;
        if (!pr_primed)
        begin
            pr_ref = lvl;
            pr_primed = 1'b1;
        end
        else
        begin
            b = (lvl == pr_ref);
            pr_ref = lvl;
            if (b)
            begin
                was = pr_ones;
                if (pr_ones < 3'd7)
                    pr_ones = pr_ones + 3'd1;
                if (pr_ones == 3'd7 && was == 3'd6)
                begin
                    if (pr_in_frame)
                    begin
                        push_word(hnrd_pkg::KIND_ABORT, 8'd0, 1'b1);
                        pr_in_frame = 1'b0;
                        restart_frame_state();
                    end
                end
                else if (pr_in_frame && pr_ones < 3'd7)
                    shift_frame_bit(1'b1);
            end
            else if (pr_ones == 3'd5)
                pr_ones = 3'd0;
            else if (pr_ones == 3'd6)
            begin
                pr_ones = 3'd0;
                close_on_flag();
            end
            else
            begin
                pr_ones = 3'd0;
                if (pr_in_frame)
                    shift_frame_bit(1'b0);
            end
        end
    endfunction

    // Offers one line symbol, in bursts with random gaps between them.
    task automatic drive_symbol(input logic lvl);
        int gap;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(200, 600);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 6);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, lvl};
        do @(posedge clk); while (!s_tready);
        burst_left--;
        symbols_sent++;
        tx_level = lvl;
        deframe_symbol(lvl);
    endtask

    // NRZI: a one keeps the level, a zero toggles it.
    task automatic send_line_bit(input logic b);
        drive_symbol(b ? tx_level : ~tx_level);
    endtask

    task automatic send_plain_bits(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++)
            send_line_bit(bits[i]);
        tx_ones = 0;
        tx_crc = hnrd_pkg::CRC_PRESET;
    endtask

    task automatic send_data_bits(input logic [31:0] bits, input int n);
        logic fb;
        for (int i = 0; i < n; i++)
        begin
            send_line_bit(bits[i]);
            fb = tx_crc[0] ^ bits[i];
            tx_crc = (tx_crc >> 1) ^ (fb ? hnrd_pkg::CRC_POLY : 16'h0000);
            if (bits[i])
            begin
                tx_ones++;
                if (tx_ones == 5)
                begin
                    send_line_bit(1'b0);
                    tx_ones = 0;
                end
            end
            else
                tx_ones = 0;
        end
    endtask

    task automatic send_fcs(input logic [15:0] mask);
        logic [15:0] fcs;
        fcs = ~tx_crc ^ mask;
        send_data_bits({16'd0, fcs}, 16);
    endtask

    // Stops the sender until every expected word is out and the pipeline is empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_frame(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {hnrd_pkg::REG_MIN_FRAME, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pr_min = value;
        settings_used++;
        // Read back through a fresh setup and access pair.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            $display("%0t: min_frame_bytes readback expected %08h actual %08h",
                     $time, {24'd0, value}, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_frame();
        int n;
        int ending;
        logic [7:0] byte_val;
        if (!tx_open)
            send_plain_bits(32'h7E, 8);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (n)
        begin
            case ($urandom_range(0, 7))
                0: byte_val = 8'hFF;
                1: byte_val = 8'h7E;
                2: byte_val = 8'h00;
                default: byte_val = 8'($urandom);
            endcase
            send_data_bits({24'd0, byte_val}, 8);
        end
        ending = $urandom_range(0, 19);
        if (ending == 2 || ending == 3)
        begin
            send_plain_bits(32'h7F, 7);
            tx_open = 1'b0;
        end
        else
        begin
            if (ending < 2)
                send_data_bits($urandom, $urandom_range(1, 7));
            else if (ending > 4)
                send_fcs(($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0);
            send_plain_bits(32'h7E, 8);
            tx_open = 1'b1;
            if ($urandom_range(0, 5) == 0)
                send_plain_bits(32'h7E, 8);
        end
    endtask

    // Mostly well-formed frames; the rest is line noise, junk bits and idle marks.
    task automatic random_traffic(input int target);
        int start;
        int actions;
        int pick;
        start = symbols_sent;
        actions = 0;
        while (symbols_sent - start < target)
        begin
            actions++;
            if (actions == 5 || $urandom_range(0, 29) == 0)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 72)
                send_random_frame();
            else
            begin
                if (pick < 82)
                    repeat ($urandom_range(1, 30)) drive_symbol(1'($urandom_range(0, 1)));
                else if (pick < 92)
                    send_plain_bits($urandom, $urandom_range(1, 30));
                else
                    repeat ($urandom_range(8, 20)) send_line_bit(1'b1);
                tx_ones = 0;
                tx_open = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    m_tready <= 1'b0;
                    ready_hold <= $urandom_range(0, 11);
                end
                2:
                begin
                    m_tready <= 1'b1;
                    ready_hold <= $urandom_range(40, 160);
                end
                default:
                begin
                    m_tready <= 1'b1;
                    ready_hold <= $urandom_range(0, 5);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (m_tlast)
                frame_ends++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: expected no word, actual kind %0d byte %02h last %0b bytes %0d",
                         $time, m_tuser, m_tdata[7:0], m_tlast, m_tdata[19:8]);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                    m_tlast !== want.last || m_tdata[19:8] !== want.bytes ||
                    m_tdata[23:20] !== 4'd0)
                begin
                    $display("%0t: expected kind %0d byte %02h last %0b bytes %0d,",
                             $time, want.kind, want.data, want.last, want.bytes);
                    $display("    actual kind %0d byte %02h last %0b bytes %0d pad %h",
                             m_tuser, m_tdata[7:0], m_tlast, m_tdata[19:8], m_tdata[23:20]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish in %0d cycles", $time, LIMIT_CYCLES);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset value of min_frame_bytes.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            case (stim_rows[r].seg)
                SEG_RAW:
                    for (int i = 0; i < stim_rows[r].nbits; i++)
                        drive_symbol(stim_rows[r].bits[i]);
                SEG_PLAIN:
                    send_plain_bits(stim_rows[r].bits, stim_rows[r].nbits);
                SEG_DATA:
                    send_data_bits(stim_rows[r].bits, stim_rows[r].nbits);
                default:
                    send_fcs(stim_rows[r].bits[15:0]);
            endcase
            if (stim_rows[r].check)
                expected_words[expected_words.size() - 1] =
                    '{kind: stim_rows[r].want_kind, data: 8'd0, last: 1'b1,
                      bytes: stim_rows[r].want_bytes};
        end
        tx_open = 1'b1;

        drain_results();
        write_min_frame(8'd255);
        random_traffic(180);

        drain_results();
        write_min_frame(8'd3);
        random_traffic(200);

        drain_results();
        write_min_frame(8'($urandom_range(4, 40)));
        random_traffic(180);

        drain_results();
        $display("Sent %0d line symbols under %0d min_frame_bytes settings.",
                 symbols_sent, settings_used);
        $display("Checked %0d output words, %0d of them frame ends.", words_checked, frame_ends);
        if (error_count == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
